// File: rtl/core/tfd_pkg.sv
// Shared types and constants for the TCP frame deframer.
// No dependencies; used by every module in rtl/core.
package tfd_pkg;

  localparam int unsigned HdrBytes = 10;

  localparam logic [3:0] HdrLastIdx   = 4'(HdrBytes - 1);
  localparam logic [3:0] HdrShiftBytes = 4'd8;

  localparam logic [15:0] StartWordReset = 16'h51EB;
  localparam logic [31:0] MaxLenReset    = 32'h7FFF_FFFF;

  localparam logic CfgIdxStartWord = 1'b0;
  localparam logic CfgIdxMaxLen    = 1'b1;

  typedef enum logic [1:0] {
    KindDesc = 2'd0,
    KindStr  = 2'd1,
    KindPay  = 2'd2,
    KindErr  = 2'd3
  } item_kind_e;

  typedef enum logic {
    ErrBadStart  = 1'b0,
    ErrLenOver   = 1'b1
  } error_code_e;

  typedef struct packed {
    logic [15:0] start_word;
    logic [31:0] max_payload_len;
  } tfd_cfg_t;

  typedef struct packed {
    item_kind_e  item_kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_type;
    logic [15:0] head_len;
    logic [31:0] payload_len;
    error_code_e error_code;
    logic        last_of_frame;
  } tfd_result_t;

endpackage

// File: rtl/core/tfd_cfg_regs.sv
// Configuration registers: expected start word and payload length limit.
// Depends on tfd_pkg.
module tfd_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output tfd_pkg::tfd_cfg_t cfg_o
);

  logic [15:0] start_word_q;
  logic [31:0] max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_word_q <= tfd_pkg::StartWordReset;
      max_len_q    <= tfd_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tfd_pkg::CfgIdxStartWord: start_word_q <= cfg_data_i[15:0];
        tfd_pkg::CfgIdxMaxLen:    max_len_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.start_word      = start_word_q;
  assign cfg_o.max_payload_len = max_len_q;

endmodule

// File: rtl/core/tfd_parser.sv
// Frame parser: header collection, checks and section counting, one beat per cycle with step_i high.
// Depends on tfd_pkg.
module tfd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tfd_pkg::tfd_cfg_t    cfg_i,
  input  logic                 step_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 res_valid_o,
  output tfd_pkg::tfd_result_t res_o
);

  localparam logic [1:0] PhHdr = 2'd0;
  localparam logic [1:0] PhStr = 2'd1;
  localparam logic [1:0] PhPay = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  count_q, count_d;
  logic [63:0] hdr_q, hdr_d;
  logic [15:0] type_q, type_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] held_len_q, held_len_d;

  logic [31:0] remain_dec;
  logic [15:0] hdr_start;
  logic [15:0] hdr_hlen;
  logic [31:0] hdr_plen;

  assign remain_dec = remain_q - 32'd1;
  assign hdr_start  = hdr_d[63:48];
  assign hdr_hlen   = hdr_d[47:32];
  assign hdr_plen   = hdr_d[31:0];

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    hdr_d       = hdr_q;
    type_d      = type_q;
    remain_d    = remain_q;
    held_len_d  = held_len_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_q)
      PhStr, PhPay: begin
        res_valid_o       = 1'b1;
        res_o.item_kind   = (phase_q == PhStr) ? tfd_pkg::KindStr : tfd_pkg::KindPay;
        res_o.data_byte   = rx_byte_i;
        res_o.frame_type  = type_q;
        res_o.head_len    = hdr_q[47:32];
        res_o.payload_len = held_len_q;
        res_o.error_code  = tfd_pkg::ErrBadStart;
        remain_d          = remain_dec;
        if (remain_dec == 32'd0) begin
          if (phase_q == PhStr && held_len_q != 32'd0) begin
            phase_d  = PhPay;
            remain_d = held_len_q;
          end else begin
            phase_d             = PhHdr;
            res_o.last_of_frame = 1'b1;
          end
        end
      end
      default: begin
        phase_d = PhHdr;
        if (count_q < tfd_pkg::HdrShiftBytes) begin
          hdr_d = {hdr_q[55:0], rx_byte_i};
        end else begin
          type_d = {type_q[7:0], rx_byte_i};
        end
        count_d = count_q + 4'd1;
        if (count_q == tfd_pkg::HdrLastIdx) begin
          count_d             = 4'd0;
          res_valid_o         = 1'b1;
          res_o.last_of_frame = 1'b1;
          if (hdr_start != cfg_i.start_word) begin
            res_o.item_kind  = tfd_pkg::KindErr;
            res_o.error_code = tfd_pkg::ErrBadStart;
          end else if (hdr_plen > cfg_i.max_payload_len) begin
            res_o.item_kind   = tfd_pkg::KindErr;
            res_o.error_code  = tfd_pkg::ErrLenOver;
            res_o.frame_type  = type_d;
            res_o.head_len    = hdr_hlen;
            res_o.payload_len = hdr_plen;
          end else begin
            held_len_d        = hdr_plen;
            res_o.item_kind   = tfd_pkg::KindDesc;
            res_o.error_code  = tfd_pkg::ErrBadStart;
            res_o.frame_type  = type_d;
            res_o.head_len    = hdr_hlen;
            res_o.payload_len = hdr_plen;
            if (hdr_hlen != 16'd0) begin
              phase_d             = PhStr;
              remain_d            = {16'd0, hdr_hlen};
              res_o.last_of_frame = 1'b0;
            end else if (hdr_plen != 32'd0) begin
              phase_d             = PhPay;
              remain_d            = hdr_plen;
              res_o.last_of_frame = 1'b0;
            end else begin
              remain_d = 32'd0;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHdr;
      count_q    <= 4'd0;
      hdr_q      <= 64'd0;
      type_q     <= 16'd0;
      remain_q   <= 32'd0;
      held_len_q <= 32'd0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      hdr_q      <= hdr_d;
      type_q     <= type_d;
      remain_q   <= remain_d;
      held_len_q <= held_len_d;
    end
  end

endmodule

// File: rtl/core/tfd_out_reg.sv
// Result register holding one output beat until the consumer takes it.
// Depends on tfd_pkg.
module tfd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  tfd_pkg::tfd_result_t res_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output tfd_pkg::tfd_result_t res_o
);

  logic                 valid_q;
  tfd_pkg::tfd_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/core/tcp_frame_deframer.sv
// Top level of the TCP frame deframer: config registers, parser and result register.
// Depends on tfd_pkg, tfd_cfg_regs, tfd_parser and tfd_out_reg.
//
//   Channel   Handshake              Payload
//   rx        rx_valid_i/rx_ready_o  rx_byte_i
//   out       out_valid_o/out_ready_i item_kind_o .. last_of_frame_o
//   cfg       cfg_we_i               cfg_index_i, cfg_data_i
//
// One byte is taken every cycle while rx_ready_o is high; its result, if any, is visible the next cycle.
// The parser state and the result register set the rate: one beat per clock unless the output stalls.
// A stalled output holds rx_ready_o low only while its register is full.
// Reset returns the configuration to its defaults and the parser to header collection.
module tcp_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] frame_type_o,
  output logic [15:0] head_len_o,
  output logic [31:0] payload_len_o,
  output logic        error_code_o,
  output logic        last_of_frame_o
);

  tfd_pkg::tfd_cfg_t    cfg;
  tfd_pkg::tfd_result_t parse_res;
  tfd_pkg::tfd_result_t out_res;
  logic                 parse_valid;
  logic                 rx_fire;

  assign rx_ready_o = !out_valid_o || out_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  tfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (rx_fire),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (parse_valid),
    .res_o       (parse_res)
  );

  tfd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (rx_fire && parse_valid),
    .res_i       (parse_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign item_kind_o     = out_res.item_kind;
  assign data_byte_o     = out_res.data_byte;
  assign frame_type_o    = out_res.frame_type;
  assign head_len_o      = out_res.head_len;
  assign payload_len_o   = out_res.payload_len;
  assign error_code_o    = out_res.error_code;
  assign last_of_frame_o = out_res.last_of_frame;

endmodule

// File: tb/tcp_frame_deframer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tcp_frame_deframer: streams frames, bad start words and
// over-limit lengths through the byte channel and checks every output beat in order.
// Depends on tfd_pkg and the deframer RTL.
module tcp_frame_deframer_tb;

  typedef enum logic [1:0] {
    ParseHeader  = 2'd0,
    ParseString  = 2'd1,
    ParsePayload = 2'd2
  } parse_phase_e;

  typedef enum int unsigned {
    IdleNone = 0,
    IdleFull = 1,
    IdleSome = 2
  } idle_mode_e;

  localparam int unsigned MaxGap     = 18;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned ByteTarget = 1200;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = tfd_pkg::CfgIdxStartWord;
  logic [31:0] cfg_data_i  = '0;
  logic        rx_valid_i  = 1'b0;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  item_kind_o;
  logic [7:0]  data_byte_o;
  logic [15:0] frame_type_o;
  logic [15:0] head_len_o;
  logic [31:0] payload_len_o;
  logic        error_code_o;
  logic        last_of_frame_o;

  tcp_frame_deframer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .item_kind_o    (item_kind_o),
    .data_byte_o    (data_byte_o),
    .frame_type_o   (frame_type_o),
    .head_len_o     (head_len_o),
    .payload_len_o  (payload_len_o),
    .error_code_o   (error_code_o),
    .last_of_frame_o(last_of_frame_o)
  );

  logic [7:0]           wire_bytes[$];
  tfd_pkg::tfd_result_t due_beats[$];
  tfd_pkg::tfd_result_t seen_beat;
  tfd_pkg::tfd_result_t want_beat;
  int unsigned queued_bytes = 0;
  int unsigned mismatch_cnt = 0;
  bit          send_busy    = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  idle_mode_e  send_mode    = IdleSome;
  idle_mode_e  recv_mode    = IdleSome;
  bit          hold_armed   = 1'b0;
  int unsigned hold_left    = 0;

  parse_phase_e parse_phase = ParseHeader;
  logic [3:0]   hdr_count   = '0;
  logic [63:0]  hdr_word    = '0;
  logic [15:0]  type_word   = '0;
  logic [31:0]  bytes_left  = '0;
  logic [31:0]  frame_plen  = '0;
  logic [15:0]  want_start  = tfd_pkg::StartWordReset;
  logic [31:0]  len_limit   = tfd_pkg::MaxLenReset;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(idle_mode_e mode);
    int unsigned gap;
    gap = 0;
    if (mode == IdleFull) begin
      gap = $urandom_range(0, MaxGap);
    end else if (mode == IdleSome && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(0, MaxGap);
    end
    return gap;
  endfunction

  // Advances the expected parser state by one received byte and records the beat it causes.
  function automatic void parse_byte(logic [7:0] b);
    tfd_pkg::tfd_result_t r;
    r = '0;
    r.frame_type  = type_word;
    r.head_len    = hdr_word[47:32];
    r.payload_len = frame_plen;
    case (parse_phase)
      ParseString: begin
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == '0) begin
          if (frame_plen != '0) begin
            parse_phase = ParsePayload;
            bytes_left  = frame_plen;
          end else begin
            parse_phase     = ParseHeader;
            r.last_of_frame = 1'b1;
          end
        end
        r.item_kind = tfd_pkg::KindStr;
        r.data_byte = b;
        due_beats.push_back(r);
      end
      ParsePayload: begin
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == '0) begin
          parse_phase     = ParseHeader;
          r.last_of_frame = 1'b1;
        end
        r.item_kind = tfd_pkg::KindPay;
        r.data_byte = b;
        due_beats.push_back(r);
      end
      default: begin
        parse_phase = ParseHeader;
        if (hdr_count < tfd_pkg::HdrShiftBytes) begin
          hdr_word = {hdr_word[55:0], b};
        end else begin
          type_word = {type_word[7:0], b};
        end
        hdr_count = hdr_count + 4'd1;
        if (hdr_count == 4'(tfd_pkg::HdrBytes)) begin
          hdr_count       = '0;
          r.frame_type    = type_word;
          r.head_len      = hdr_word[47:32];
          r.payload_len   = hdr_word[31:0];
          r.last_of_frame = 1'b1;
          if (hdr_word[63:48] != want_start) begin
            r               = '0;
            r.item_kind     = tfd_pkg::KindErr;
            r.error_code    = tfd_pkg::ErrBadStart;
            r.last_of_frame = 1'b1;
          end else if (hdr_word[31:0] > len_limit) begin
            r.item_kind  = tfd_pkg::KindErr;
            r.error_code = tfd_pkg::ErrLenOver;
          end else begin
            frame_plen = hdr_word[31:0];
            r.item_kind = tfd_pkg::KindDesc;
            if (hdr_word[47:32] != '0) begin
              parse_phase     = ParseString;
              bytes_left      = {16'd0, hdr_word[47:32]};
              r.last_of_frame = 1'b0;
            end else if (frame_plen != '0) begin
              parse_phase     = ParsePayload;
              bytes_left      = frame_plen;
              r.last_of_frame = 1'b0;
            end else begin
              bytes_left = '0;
            end
          end
          due_beats.push_back(r);
        end
      end
    endcase
  endfunction

  function automatic void queue_header(logic [15:0] sw, logic [15:0] hl, logic [31:0] pl,
                                       logic [15:0] ft);
    logic [79:0] hdr;
    hdr = {sw, hl, pl, ft};
    for (int i = int'(tfd_pkg::HdrBytes) - 1; i >= 0; i--) begin
      wire_bytes.push_back(hdr[i*8 +: 8]);
    end
    queued_bytes += tfd_pkg::HdrBytes;
  endfunction

  function automatic void queue_body(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      wire_bytes.push_back(8'($urandom));
    end
    queued_bytes += n;
  endfunction

  // Mostly well-formed frames; the rest are over-limit headers, bad start words and noise.
  function automatic void queue_random_frame();
    int unsigned pick;
    logic [15:0] sw;
    logic [15:0] hl;
    logic [31:0] pl;
    logic [15:0] ft;
    pick = $urandom_range(0, 99);
    ft   = 16'($urandom);
    hl   = 16'($urandom);
    pl   = $urandom;
    if (pick < 70) begin
      hl = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 24)) :
                                         16'($urandom_range(0, 4));
      pl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 6);
      if (pl > len_limit) begin
        pl = len_limit;
      end
      queue_header(want_start, hl, pl, ft);
      queue_body(32'(hl) + pl);
    end else if (pick < 84 && len_limit != '1) begin
      pl = len_limit + 32'd1 + ($urandom % (32'hFFFF_FFFF - len_limit));
      queue_header(want_start, hl, pl, ft);
    end else if (pick < 94) begin
      sw = 16'($urandom);
      if ($urandom_range(0, 1) == 1) begin
        sw[15:8] = want_start[15:8];
      end
      if (sw == want_start) begin
        sw[0] = ~sw[0];
      end
      queue_header(sw, hl, pl, ft);
    end else begin
      queue_body(tfd_pkg::HdrBytes);
    end
  endfunction

  function automatic void queue_random(int unsigned n);
    int unsigned first;
    first = queued_bytes;
    while (queued_bytes - first < n) begin
      queue_random_frame();
    end
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == tfd_pkg::CfgIdxStartWord) begin
      want_start = val[15:0];
    end else begin
      len_limit = val;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (wire_bytes.size() != 0 || send_busy || due_beats.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
    end else begin
      if (rx_valid_i && rx_ready_o) begin
        parse_byte(rx_byte_i);
        send_busy = 1'b0;
        send_gap  = draw_gap(send_mode);
      end
      if (!send_busy) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (wire_bytes.size() != 0) begin
          rx_byte_i <= wire_bytes.pop_front();
          send_busy = 1'b1;
        end
      end
      rx_valid_i <= send_busy;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen_beat.item_kind     = tfd_pkg::item_kind_e'(item_kind_o);
        seen_beat.data_byte     = data_byte_o;
        seen_beat.frame_type    = frame_type_o;
        seen_beat.head_len      = head_len_o;
        seen_beat.payload_len   = payload_len_o;
        seen_beat.error_code    = tfd_pkg::error_code_e'(error_code_o);
        seen_beat.last_of_frame = last_of_frame_o;
        if (due_beats.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("Unexpected beat: kind %0d data %h", item_kind_o, data_byte_o);
          end
        end else begin
          want_beat = due_beats.pop_front();
          if (seen_beat.item_kind !== want_beat.item_kind ||
              seen_beat.data_byte !== want_beat.data_byte ||
              seen_beat.frame_type !== want_beat.frame_type ||
              seen_beat.head_len !== want_beat.head_len ||
              seen_beat.payload_len !== want_beat.payload_len ||
              seen_beat.error_code !== want_beat.error_code ||
              seen_beat.last_of_frame !== want_beat.last_of_frame) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("Beat mismatch (expected/actual): kind %0d/%0d data %h/%h type %h/%h",
                       want_beat.item_kind, seen_beat.item_kind, want_beat.data_byte,
                       seen_beat.data_byte, want_beat.frame_type, seen_beat.frame_type);
              $display("  head_len %h/%h payload_len %h/%h error %0d/%0d last %0d/%0d",
                       want_beat.head_len, seen_beat.head_len, want_beat.payload_len,
                       seen_beat.payload_len, want_beat.error_code, seen_beat.error_code,
                       want_beat.last_of_frame, seen_beat.last_of_frame);
            end
          end
        end
        recv_gap = draw_gap(recv_mode);
      end
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default settings: empty frame, one string and one payload byte, length just over.
    queue_header(tfd_pkg::StartWordReset, 16'd0, 32'd0, 16'hFFFF);
    queue_header(tfd_pkg::StartWordReset, 16'd1, 32'd1, 16'h0000);
    wire_bytes.push_back(8'h00);
    wire_bytes.push_back(8'hFF);
    queued_bytes += 2;
    queue_header(tfd_pkg::StartWordReset, 16'h8000, 32'h8000_0000, 16'h1234);
    queue_random(60);
    wait_idle();

    // Zero start word and zero limit: every frame with a payload is rejected.
    write_reg(tfd_pkg::CfgIdxStartWord, 32'h0000_0000);
    write_reg(tfd_pkg::CfgIdxMaxLen, 32'h0000_0000);
    send_mode = IdleFull;
    recv_mode = IdleFull;
    queue_header(16'h0000, 16'hFFFF, 32'd1, 16'hFFFF);
    queue_header(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    queue_header(16'h0000, 16'h0000, 32'd0, 16'h0000);
    queue_random(100);
    wait_idle();

    // All-ones settings, no idling, with one long frame.
    write_reg(tfd_pkg::CfgIdxStartWord, 32'h0000_FFFF);
    write_reg(tfd_pkg::CfgIdxMaxLen, 32'hFFFF_FFFF);
    send_mode = IdleNone;
    recv_mode = IdleNone;
    queue_header(16'hFFFF, 16'd257, 32'd300, 16'($urandom));
    queue_body(557);
    queue_random(150);
    wait_idle();

    // Output held off while bytes keep coming, so the block must stall its input.
    write_reg(tfd_pkg::CfgIdxStartWord, {16'd0, tfd_pkg::StartWordReset});
    write_reg(tfd_pkg::CfgIdxMaxLen, tfd_pkg::MaxLenReset);
    send_mode  = IdleNone;
    recv_mode  = IdleSome;
    hold_armed = 1'b1;
    queue_random(150);
    wait_idle();

    while (queued_bytes < ByteTarget) begin
      write_reg(tfd_pkg::CfgIdxStartWord, {16'd0, 16'($urandom)});
      write_reg(tfd_pkg::CfgIdxMaxLen,
                ($urandom_range(0, 1) == 1) ? $urandom_range(0, 12) : $urandom);
      send_mode = idle_mode_e'($urandom_range(0, 2));
      recv_mode = idle_mode_e'($urandom_range(0, 2));
      queue_random(120);
      wait_idle();
    end

    repeat (8) @(negedge clk_i);
    if (mismatch_cnt == 0 && due_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/tfd_pkg.sv
rtl/core/tfd_cfg_regs.sv
rtl/core/tfd_parser.sv
rtl/core/tfd_out_reg.sv
rtl/core/tcp_frame_deframer.sv
tb/tcp_frame_deframer_tb.sv
